// ----- rtl/greedy_word_wrapper_macros.svh -----
// assertion macros for the greedy word wrapper
// all macros sample on clk_i and are disabled while rst_ni is low
`ifndef GREEDY_WORD_WRAPPER_MACROS_SVH
`define GREEDY_WORD_WRAPPER_MACROS_SVH

// condition must hold at every clock edge out of reset
`define GWW_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GWW_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gww_pkg.sv -----
// shared types and constants of the greedy word wrapper
// no dependencies
`default_nettype none

package gww_pkg;

  // request codes
  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_ECHO  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [7:0] CHAR_SP = 8'd32;

  // register file
  localparam int unsigned PADDR_W       = 3;
  localparam int unsigned PDATA_W       = 32;
  localparam logic        REG_LINE_WIDTH = 1'b0;
  localparam logic [7:0]  LINE_WIDTH_RST = 8'd80;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic       string_end;
  } gww_in_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        is_column_reply;
    logic [15:0] column_value;
    logic        last_result;
  } gww_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRAP,
    ST_CHAR,
    ST_TAIL
  } gww_state_e;

  // what follows the word commit for the current word
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_NL,
    TAIL_SP,
    TAIL_REPLY
  } gww_tail_e;

endpackage

`default_nettype wire

// ----- rtl/gww_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module gww_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/greedy_word_wrapper.sv -----
// Greedy word wrapper. Text bytes are collected into a word buffer in a
// MAX_WORD-deep RAM; a word is written out at a space, a newline, a string end,
// a column query or when the buffer fills, preceded by a newline if it would run
// past line_width (0 = no wrapping). A byte that only extends the word, an echo
// or an unused request leaves the wrapper idle. An item that commits a word
// passes the wrap state, where a wrap newline or a pending space goes out,
// then reads the word out of the RAM and sends a newline or a column reply if
// one follows. A separator or query with no buffered word emits nothing in the
// wrap state. Characters come from the RAM read port, one result per cycle
// while the output does not stall. The output register lets the next item in
// while the last result waits. Line width sits at APB address 0.
// depends on gww_pkg, gww_ram and greedy_word_wrapper_macros.svh
`default_nettype none
`include "greedy_word_wrapper_macros.svh"

module greedy_word_wrapper
  import gww_pkg::*;
#(
  parameter int unsigned MAX_WORD    = 32,
  parameter int unsigned COLUMN_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input words
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire gww_in_t              in_data_i,
  // output words
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output gww_out_t                  out_data_o,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic      [PDATA_W-1:0]   prdata,
  output logic                      pready
);

  localparam int unsigned AW = $clog2(MAX_WORD);
  localparam int unsigned LW = $clog2(MAX_WORD + 1);
  localparam int unsigned CW = COLUMN_BITS;

  gww_state_e           st_q, st_d;
  gww_tail_e            tail_q, tail_d;
  logic [LW-1:0]        len_q, len_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic                 sp_q, sp_d;
  logic [CW-1:0]        col_q, col_d;
  logic [7:0]           width_q;
  logic                 out_valid_q, out_valid_d;
  gww_out_t             out_q, out_d;

  logic                 in_fire;
  logic                 ok;
  logic                 emit;
  gww_out_t             res;
  logic                 is_sep;
  logic [LW-1:0]        len_inc;
  logic                 wrap_hit;
  logic                 last_char;
  logic                 tail_emit;
  logic [CW-1:0]        col_inc;
  logic [CW:0]          col_need;
  logic                 ram_we;
  logic [7:0]           ram_rdata;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_LINE_WIDTH) begin
      prdata = {{(PDATA_W-8){1'b0}}, width_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= LINE_WIDTH_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_LINE_WIDTH) begin
      width_q <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------- helpers
  assign in_ready_o = (st_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign ok         = !out_valid_q || out_ready_i;
  assign is_sep     = (in_data_i.char_code == CHAR_NL) || (in_data_i.char_code == CHAR_SP);
  assign len_inc    = len_q + LW'(1);
  assign col_inc    = (col_q == {CW{1'b1}}) ? col_q : col_q + CW'(1);
  assign col_need   = {1'b0, col_q} + (CW+1)'(len_q) + (CW+1)'(sp_q);
  assign wrap_hit   = (width_q != 8'd0) && (col_q != '0) &&
                      (col_need > (CW+1)'(width_q));
  assign last_char  = (LW'(idx_q) + LW'(1)) == len_q;
  assign tail_emit  = (tail_q == TAIL_NL) || (tail_q == TAIL_REPLY) ||
                      (tail_q == TAIL_SP && sp_q);

  // ---------------------------------------------------------------- word buffer
  // reads run every cycle at idx_d so ram_rdata always holds entry idx_q;
  // a byte written on accept is read back during the wrap cycle, before any
  // character is emitted
  gww_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WORD)
  ) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (in_data_i.char_code),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.req_type)
            REQ_CHAR: begin
              if (is_sep || in_data_i.string_end || len_inc == LW'(MAX_WORD)) begin
                st_d = ST_WRAP;
              end
            end
            REQ_QUERY: st_d = ST_WRAP;
            default:   st_d = ST_IDLE;
          endcase
        end
      end
      ST_WRAP: begin
        if (len_q == '0) begin
          st_d = ST_TAIL;
        end else if (!(wrap_hit || sp_q) || ok) begin
          st_d = ST_CHAR;
        end
      end
      ST_CHAR: begin
        if (ok && last_char) begin
          // only a newline or a reply still has to follow the word
          st_d = (tail_q == TAIL_NL || tail_q == TAIL_REPLY) ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (!tail_emit || ok) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    tail_d = tail_q;
    len_d  = len_q;
    idx_d  = idx_q;
    sp_d   = sp_q;
    col_d  = col_q;
    ram_we = 1'b0;
    emit   = 1'b0;
    res    = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.req_type)
            REQ_CHAR: begin
              if (in_data_i.char_code == CHAR_NL) begin
                tail_d = TAIL_NL;
              end else if (in_data_i.char_code == CHAR_SP) begin
                tail_d = TAIL_SP;
              end else begin
                tail_d = TAIL_NONE;
                ram_we = 1'b1;
                len_d  = len_inc;
              end
            end
            REQ_ECHO: begin
              col_d = '0;
              sp_d  = 1'b0;
            end
            REQ_QUERY: tail_d = TAIL_REPLY;
            default: ;
          endcase
        end
      end
      ST_WRAP: begin
        // word is known nonempty here, so nothing emitted now is the last word
        if (len_q != '0) begin
          if (wrap_hit) begin
            emit         = 1'b1;
            res.out_char = CHAR_NL;
            if (ok) begin
              col_d = '0;
              sp_d  = 1'b0;
            end
          end else if (sp_q) begin
            emit         = 1'b1;
            res.out_char = CHAR_SP;
            if (ok) begin
              col_d = col_inc;
              sp_d  = 1'b0;
            end
          end
        end
      end
      ST_CHAR: begin
        emit            = 1'b1;
        res.out_char    = ram_rdata;
        res.last_result = last_char && (tail_q == TAIL_NONE || tail_q == TAIL_SP);
        if (ok) begin
          col_d = col_inc;
          if (last_char) begin
            idx_d = '0;
            len_d = '0;
            // the separating space becomes pending once the word is out
            if (tail_q == TAIL_SP) begin
              sp_d = 1'b1;
            end
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      ST_TAIL: begin
        case (tail_q)
          TAIL_NL: begin
            emit            = 1'b1;
            res.out_char    = CHAR_NL;
            res.last_result = 1'b1;
            if (ok) begin
              col_d = '0;
              sp_d  = 1'b0;
            end
          end
          TAIL_SP: begin
            // a space already pending goes out, the new one stays pending
            if (sp_q) begin
              emit            = 1'b1;
              res.out_char    = CHAR_SP;
              res.last_result = 1'b1;
              if (ok) begin
                col_d = col_inc;
              end
            end
            if (!sp_q || ok) begin
              sp_d = 1'b1;
            end
          end
          TAIL_REPLY: begin
            emit                = 1'b1;
            res.is_column_reply = 1'b1;
            res.column_value    = 16'(col_q);
            res.last_result     = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit && ok) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      tail_q      <= TAIL_NONE;
      len_q       <= '0;
      idx_q       <= '0;
      sp_q        <= 1'b0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      tail_q      <= tail_d;
      len_q       <= len_d;
      idx_q       <= idx_d;
      sp_q        <= sp_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // ---------------------------------------------------------------- assertions
  `GWW_ASSERT(a_idle_word_fits, (st_q != ST_IDLE) || (len_q < LW'(MAX_WORD)), "word buffer full while idle")
  `GWW_ASSERT(a_char_no_space, (st_q != ST_CHAR) || (!sp_q && LW'(idx_q) < len_q), "bad word readout state")
  `GWW_ASSERT_NEXT(a_last_ends_item, emit && ok && res.last_result, st_q == ST_IDLE, "last word did not end the item")

endmodule

`default_nettype wire
